// ----- design/assert_macros.svh -----
// Assertion macros used by the checker module of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fcgi_pkg.sv -----
// Shared types and constants of the FastCGI record deframer.
// No dependencies; used by every module of the block.
package fcgi_pkg;

  localparam int HDR_BYTES = 8;
  localparam int HDR_CNT_W = $clog2(HDR_BYTES);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_FRAME_END = 3'd2,
    KIND_CLEAN     = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [15:0] record_type;
    logic [15:0] request_id;
    logic [15:0] content_length;
    logic        frame_end;
  } result_t;

endpackage

// ----- design/fastcgi_record_deframer.sv -----
// FastCGI record deframer, top level.
// Depends on fcgi_pkg, fcgi_in_stage, fcgi_parser and fcgi_out_stage.
//
// Usage: the slave channel (in_*) carries the raw byte stream, one byte per
// transaction, with in_tuser low; a transaction with in_tuser high marks the
// end of the stream and its byte is ignored. The master channel (out_*)
// carries one result per record header, per payload byte, per record end
// after padding and per end of stream. Header bytes other than the last one,
// and padding bytes other than the last one, produce no result.
// out_tuser gives the result kind, and out_tlast is high on the result that
// completes a record including its padding.
// Throughput is one transaction per clock cycle while the output is not
// stalled. An accepted byte is held in the input register, and its result
// is loaded into the result register as the byte moves on.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// parser to the start of a header. When the receiver holds out_tready low,
// the result stays in place and the input register still takes one more
// transaction; bytes that produce no result keep flowing past a stalled
// output. An end-of-stream report returns the parser to its reset state.
module fastcgi_record_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] op: low = stream byte, high = end of stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] out_byte, [23:8] record_type,
                                  // [39:24] request_id, [55:40] content_length
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // frame_end
);

  fcgi_pkg::item_t   in_item;
  fcgi_pkg::item_t   item;
  fcgi_pkg::result_t res;
  fcgi_pkg::result_t out_res;
  logic              item_valid;
  logic              res_vld;
  logic              out_free;
  logic              advance;

  assign in_item.op   = in_tuser;
  assign in_item.data = in_tdata;

  // The held item moves on when it yields nothing or the result register
  // can take what it yields.
  assign advance = item_valid && (!res_vld || out_free);

  fcgi_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  fcgi_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .step    (advance),
    .res     (res),
    .res_vld (res_vld)
  );

  fcgi_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_vld),
    .res       (res),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.content_length, out_res.request_id,
                      out_res.record_type, out_res.out_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.frame_end;

endmodule

// ----- design/fcgi_in_stage.sv -----
// Input register of the deframer: holds one accepted transaction.
// Depends on fcgi_pkg.
module fcgi_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fcgi_pkg::item_t in_item,
  input  logic            advance,
  output logic            item_valid,
  output fcgi_pkg::item_t item
);

  logic            valid_r;
  fcgi_pkg::item_t item_r;

  // The slot frees up in the same cycle that its item moves on.
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- design/fcgi_parser.sv -----
// Record state machine: header capture, payload and padding counters.
// Depends on fcgi_pkg.
module fcgi_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  fcgi_pkg::item_t   item,
  input  logic              step,
  output fcgi_pkg::result_t res,
  output logic              res_vld
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [fcgi_pkg::HDR_CNT_W-1:0]  hc_r, hc_nxt;
  logic [15:0]                     type_r, type_nxt;
  logic [15:0]                     id_r, id_nxt;
  logic [15:0]                     len_r, len_nxt;
  logic [15:0]                     pl_r, pl_nxt;
  logic [7:0]                      pad_r, pad_nxt;

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    type_nxt  = type_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    pl_nxt    = pl_r;
    pad_nxt   = pad_r;
    res       = '0;
    res_vld   = 1'b0;

    if (item.op == fcgi_pkg::OP_EOS) begin
      // A stream may only end cleanly between records.
      res_vld  = 1'b1;
      res.kind = (phase_r == PH_HEADER && hc_r == '0) ? fcgi_pkg::KIND_CLEAN
                                                      : fcgi_pkg::KIND_TRUNC;
      phase_nxt = PH_HEADER;
      hc_nxt    = '0;
      type_nxt  = '0;
      id_nxt    = '0;
      len_nxt   = '0;
      pl_nxt    = '0;
      pad_nxt   = '0;
    end else begin
      case (phase_r)
        PH_PAYLOAD: begin
          res_vld            = 1'b1;
          res.kind           = fcgi_pkg::KIND_PAYLOAD;
          res.out_byte       = item.data;
          res.record_type    = type_r;
          res.request_id     = id_r;
          res.content_length = len_r;
          pl_nxt             = pl_r - 16'd1;
          if (pl_r == 16'd1) begin
            if (pad_r == 8'd0) begin
              res.frame_end = 1'b1;
              phase_nxt     = PH_HEADER;
            end else begin
              phase_nxt = PH_PAD;
            end
          end
        end
        PH_PAD: begin
          pad_nxt = pad_r - 8'd1;
          if (pad_r == 8'd1) begin
            res_vld            = 1'b1;
            res.kind           = fcgi_pkg::KIND_FRAME_END;
            res.record_type    = type_r;
            res.request_id     = id_r;
            res.content_length = len_r;
            res.frame_end      = 1'b1;
            phase_nxt          = PH_HEADER;
          end
        end
        default: begin
          case (hc_r)
            3'd0:    type_nxt = {item.data, 8'h00};
            3'd1:    type_nxt = {type_r[15:8], item.data};
            3'd2:    id_nxt   = {item.data, 8'h00};
            3'd3:    id_nxt   = {id_r[15:8], item.data};
            3'd4:    len_nxt  = {item.data, 8'h00};
            3'd5:    len_nxt  = {len_r[15:8], item.data};
            3'd6:    pad_nxt  = item.data;
            default: ;
          endcase
          hc_nxt = hc_r + fcgi_pkg::HDR_CNT_W'(1);
          if (hc_r == fcgi_pkg::HDR_LAST) begin
            // Reserved byte closes the header; all fields are already held.
            hc_nxt             = '0;
            pl_nxt             = len_r;
            res_vld            = 1'b1;
            res.kind           = fcgi_pkg::KIND_HEADER;
            res.record_type    = type_r;
            res.request_id     = id_r;
            res.content_length = len_r;
            if (len_r != 16'd0) begin
              phase_nxt = PH_PAYLOAD;
            end else if (pad_r != 8'd0) begin
              phase_nxt = PH_PAD;
            end else begin
              res.frame_end = 1'b1;
              phase_nxt     = PH_HEADER;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hc_r    <= '0;
      type_r  <= '0;
      id_r    <= '0;
      len_r   <= '0;
      pl_r    <= '0;
      pad_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      type_r  <= type_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      pl_r    <= pl_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

// ----- design/fcgi_out_stage.sv -----
// Result register of the deframer, loaded from the parser.
// Depends on fcgi_pkg.
module fcgi_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  fcgi_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output fcgi_pkg::result_t out_res
);

  logic              valid_r;
  fcgi_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule

// ----- design/fcgi_checker.sv -----
// Port-level checks of the FastCGI record deframer, bound to the top level.
// Depends on fcgi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fcgi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  `AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `AST_IMPLIES(a_end_zero, clk, rst_n, out_tvalid && (out_tuser == fcgi_pkg::KIND_CLEAN || out_tuser == fcgi_pkg::KIND_TRUNC), out_tdata == 56'd0 && !out_tlast, "end-of-stream report carries data")
  `AST_IMPLIES(a_pad_last, clk, rst_n, out_tvalid && out_tuser == fcgi_pkg::KIND_FRAME_END, out_tlast && out_tdata[7:0] == 8'd0, "padding end without frame end")
  `AST_IMPLIES(a_byte_zero, clk, rst_n, out_tvalid && out_tuser != fcgi_pkg::KIND_PAYLOAD, out_tdata[7:0] == 8'd0, "byte field set outside payload")

endmodule

bind fastcgi_record_deframer fcgi_checker u_fcgi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
